// ===== src/srsr_pkg.sv =====
// Shared types, codes and default sizes for the resampling sample reader.
// Used by srsr_ctrl, srsr_dpath and stream_resampling_sample_reader_unit.
package srsr_pkg;

  localparam int BLOCK_FRAMES_DEF = 256;
  localparam int RING_BLOCKS_DEF  = 8;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  localparam logic [1:0] ST_SAMPLE    = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_FINISHED  = 2'd2;
  localparam logic [1:0] ST_DROPPED   = 2'd3;

  localparam logic REG_RATE     = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  localparam logic [23:0] RATE_RESET     = 24'd65536;
  localparam logic [3:0]  CHANNELS_RESET = 4'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EMIT, S_COPY_RD, S_COPY_WR,
    S_RD0, S_RD1, S_CAP1, S_MUL, S_OUT
  } state_t;

  typedef enum logic [1:0] {RD_LAST, RD_S0, RD_S1} rdsel_t;

  typedef struct packed {
    logic       take;
    logic       push_wr;
    logic       set_end;
    logic       set_done;
    logic       ch_clr;
    logic       ch_inc;
    logic       rd_en;
    rdsel_t     rd_sel;
    logic       load_prev;
    logic       adv_block;
    logic       cap_s0;
    logic       cap_s1;
    logic       mul;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_last;
    logic       phase_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       end_seen;
    logic       done;
    logic       ring_full;
    logic       need_block;
    logic       filled_zero;
    logic       loaded;
    logic       last_ch;
    logic       out_free;
  } stat_t;

endpackage

// ===== src/srsr_ctrl.sv =====
// Sequencer for push, tick and end-of-stream items of the sample reader.
// Depends on srsr_pkg; drives the command struct of srsr_dpath.
module srsr_ctrl import srsr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_SAMPLE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_LAST;
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        if (stat.req == REQ_PUSH) begin
          if (!stat.end_seen) begin
            if (stat.ring_full) begin
              st_nxt    = ST_DROPPED;
              state_nxt = S_EMIT;
            end else begin
              cmd.push_wr = 1'b1;
            end
          end
        end else if (stat.req == REQ_END) begin
          cmd.set_end = 1'b1;
        end else if (stat.req == REQ_TICK) begin
          if (stat.done) begin
            st_nxt    = ST_FINISHED;
            state_nxt = S_EMIT;
          end else if (stat.need_block && stat.filled_zero) begin
            state_nxt = S_EMIT;
            if (stat.end_seen) begin
              cmd.set_done = 1'b1;
              st_nxt       = ST_FINISHED;
            end else begin
              st_nxt = ST_NOT_READY;
            end
          end else if (stat.need_block && stat.loaded) begin
            cmd.ch_clr = 1'b1;
            state_nxt  = S_COPY_RD;
          end else begin
            cmd.adv_block = stat.need_block;
            cmd.ch_clr    = 1'b1;
            state_nxt     = S_RD0;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = st_r;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_COPY_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_nxt  = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.load_prev = 1'b1;
        if (stat.last_ch) begin
          cmd.adv_block = 1'b1;
          cmd.ch_clr    = 1'b1;
          state_nxt     = S_RD0;
        end else begin
          cmd.ch_inc = 1'b1;
          state_nxt  = S_COPY_RD;
        end
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_S0;
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        cmd.cap_s0 = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_S1;
        state_nxt  = S_CAP1;
      end
      S_CAP1: begin
        cmd.cap_s1 = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_SAMPLE;
          cmd.emit_last   = stat.last_ch;
          if (stat.last_ch) begin
            cmd.phase_step = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.ch_inc = 1'b1;
            state_nxt  = S_RD0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/srsr_dpath.sv =====
// Datapath of the sample reader: ring memory, reader state, interpolator,
// configuration registers and output register. Depends on srsr_pkg.
module srsr_dpath import srsr_pkg::*; #(
  parameter int BLOCK_FRAMES = BLOCK_FRAMES_DEF,
  parameter int RING_BLOCKS  = RING_BLOCKS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  cmd_t        cmd,
  output stat_t       stat
);

  localparam int SLOT  = BLOCK_FRAMES * MAX_CHANNELS;
  localparam int STORE = RING_BLOCKS * SLOT;
  localparam int AW    = $clog2(STORE);
  localparam int OW    = $clog2(SLOT);
  localparam int SW    = OW + 1;
  localparam int FW    = $clog2(BLOCK_FRAMES);
  localparam int PW    = FW + 17;
  localparam int RBW   = $clog2(RING_BLOCKS);
  localparam int FLW   = $clog2(RING_BLOCKS + 1);
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [PW-1:0] SPAN = PW'(BLOCK_FRAMES) << 16;

  logic [23:0]    rate_r;
  logic [3:0]     chans_r;
  logic [1:0]     req_r;
  logic [15:0]    sample_r;
  logic [RBW-1:0] wr_slot_r;
  logic [OW-1:0]  wr_off_r;
  logic [FLW-1:0] filled_r;
  logic [RBW-1:0] rd_block_r;
  logic           loaded_r;
  logic [PW-1:0]  phase_r;
  logic [15:0]    prev_r [MAX_CHANNELS];
  logic           end_seen_r;
  logic           done_r;
  logic [CW-1:0]  ch_r;
  logic [15:0]    mem_q;
  logic [15:0]    s0_r, s1_r;
  logic signed [33:0] prod_r;
  logic           out_valid_r;
  logic [1:0]     out_st_r;
  logic [2:0]     out_ch_r;
  logic [15:0]    out_val_r;
  logic           out_last_r;

  logic [15:0]    mem [STORE];

  logic [3:0]     act;
  logic [FW-1:0]  idx;
  logic [FW-1:0]  fm1;
  logic [FW+3:0]  roff;
  logic [AW-1:0]  raddr, waddr;
  logic [SW-1:0]  blk_len, wr_off_inc;
  logic [17:0]    interp;

  always_comb begin
    act = chans_r;
    if (act == 4'd0) act = 4'd1;
    if (act > 4'(MAX_CHANNELS)) act = 4'(MAX_CHANNELS);
  end

  assign idx = phase_r[16 +: FW];

  always_comb begin
    case (cmd.rd_sel)
      RD_S0:   fm1 = idx - FW'(1);
      RD_S1:   fm1 = idx;
      default: fm1 = FW'(BLOCK_FRAMES - 1);
    endcase
  end

  assign roff  = (FW+4)'(fm1) * (FW+4)'(act) + (FW+4)'(ch_r);
  assign raddr = AW'(rd_block_r) * AW'(SLOT) + AW'(roff);
  assign waddr = AW'(wr_slot_r) * AW'(SLOT) + AW'(wr_off_r);
  assign blk_len    = SW'(BLOCK_FRAMES) * SW'(act);
  assign wr_off_inc = SW'(wr_off_r) + SW'(1);

  // floor(alpha*(s1-s0)/65536) is an arithmetic shift of the product
  assign interp = {{2{s0_r[15]}}, s0_r} + prod_r[33:16];

  always_ff @(posedge clk) begin
    if (cmd.push_wr) mem[waddr] <= sample_r;
    if (cmd.rd_en)   mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r    <= in_tuser;
      sample_r <= in_tdata;
    end
    if (cmd.cap_s0) s0_r <= (idx == '0) ? prev_r[ch_r] : mem_q;
    if (cmd.cap_s1) s1_r <= mem_q;
    if (cmd.mul) begin
      prod_r <= $signed({18'd0, phase_r[15:0]})
              * ($signed({s1_r[15], s1_r}) - $signed({s0_r[15], s0_r}));
    end
    if (cmd.emit) begin
      out_st_r   <= cmd.emit_status;
      out_last_r <= cmd.emit_last;
      out_ch_r   <= (cmd.emit_status == ST_SAMPLE) ? 3'(ch_r) : 3'd0;
      out_val_r  <= (cmd.emit_status == ST_SAMPLE) ? interp[15:0] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= RATE_RESET;
      chans_r     <= CHANNELS_RESET;
      wr_slot_r   <= '0;
      wr_off_r    <= '0;
      filled_r    <= '0;
      rd_block_r  <= '0;
      loaded_r    <= 1'b0;
      phase_r     <= '0;
      end_seen_r  <= 1'b0;
      done_r      <= 1'b0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) prev_r[i] <= 16'd0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_RATE) rate_r <= cfg_data;
        else                       chans_r <= cfg_data[3:0];
      end
      if (cmd.push_wr) begin
        // close the block once it holds BLOCK_FRAMES frames
        if (wr_off_inc >= blk_len) begin
          filled_r  <= filled_r + FLW'(1);
          wr_off_r  <= '0;
          wr_slot_r <= (wr_slot_r == RBW'(RING_BLOCKS - 1)) ? '0 : wr_slot_r + RBW'(1);
        end else begin
          wr_off_r <= wr_off_inc[OW-1:0];
        end
      end
      if (cmd.set_end)  end_seen_r <= 1'b1;
      if (cmd.set_done) done_r <= 1'b1;
      if (cmd.ch_clr)      ch_r <= '0;
      else if (cmd.ch_inc) ch_r <= ch_r + CW'(1);
      if (cmd.load_prev) prev_r[ch_r] <= mem_q;
      if (cmd.adv_block) begin
        if (loaded_r) begin
          rd_block_r <= (rd_block_r == RBW'(RING_BLOCKS - 1)) ? '0 : rd_block_r + RBW'(1);
        end
        loaded_r <= 1'b1;
        filled_r <= filled_r - FLW'(1);
        if (phase_r >= SPAN) phase_r <= phase_r - SPAN;
      end
      if (cmd.phase_step) phase_r <= phase_r + PW'(rate_r);
      if (cmd.emit)            out_valid_r <= 1'b1;
      else if (out_tready)     out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.req         = req_r;
    stat.end_seen    = end_seen_r;
    stat.done        = done_r;
    stat.ring_full   = (FLW+1)'(filled_r) + (FLW+1)'(loaded_r) >= (FLW+1)'(RING_BLOCKS);
    stat.need_block  = !loaded_r || (phase_r >= SPAN);
    stat.filled_zero = (filled_r == '0);
    stat.loaded      = loaded_r;
    stat.last_ch     = (4'(ch_r) == act - 4'd1);
    stat.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_val_r, out_ch_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready)) else $error("result overwritten");
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (FLW+1)'(filled_r) + (FLW+1)'(loaded_r) <= (FLW+1)'(RING_BLOCKS))
    else $error("ring count overflow");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_status == ST_SAMPLE) |-> (phase_r < SPAN))
    else $error("phase outside block");
  a_done_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> end_seen_r) else $error("finished without end of stream");

endmodule

// ===== src/stream_resampling_sample_reader_unit.sv =====
// Top level of the varispeed stream sample reader.
// Depends on srsr_pkg, srsr_ctrl and srsr_dpath.
//
//  channel | dir | payload                                   | handshake
//  in_     | in  | tdata[15:0] sample, tuser[1:0] req_type   | in_tvalid/in_tready
//  out_    | out | tdata[2:0] channel, [18:3] value,         | out_tvalid/out_tready
//          |     | tuser[1:0] status, tlast last             |
//  cfg_    | in  | cfg_index register, cfg_data value        | cfg_valid/cfg_ready
//
// A push or end of stream passes through the dispatch state only; a dropped push or a tick
// that gives one status also passes through the emit state.
// A tick that gives samples reads, captures, multiplies and emits each channel, after
// a copy of the last frames when it moves to a new block; the ring memory is read twice per channel.
// Reset is synchronous; the ring memory is not cleared.
// A stalled output holds the sequencer only when it has a new result to load.
module stream_resampling_sample_reader_unit import srsr_pkg::*; #(
  parameter int BLOCK_FRAMES = BLOCK_FRAMES_DEF,
  parameter int RING_BLOCKS  = RING_BLOCKS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] channel, [18:3] value, [23:19] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  srsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srsr_dpath #(
    .BLOCK_FRAMES (BLOCK_FRAMES),
    .RING_BLOCKS  (RING_BLOCKS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== verif/srsr_checker.sv =====
// Checker for the varispeed stream sample reader: watches the cfg_, in_ and out_ channels,
// predicts every result with its own copy of the ring, phase and registers, and compares.
// Depends on srsr_pkg for request and status codes.
module srsr_checker import srsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES    = BLOCK_FRAMES_DEF;
  localparam int SLOTS     = RING_BLOCKS_DEF;
  localparam int CH_MAX    = MAX_CHANNELS_DEF;
  localparam int SLOT_SZ   = FRAMES * CH_MAX;
  localparam int PHASE_END = FRAMES << 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  chan;
    logic [15:0] value;
    logic        last;
  } frame_result_t;

  frame_result_t expected_q[$];

  logic [23:0]        rate_q;
  logic [3:0]         chans_q;
  logic signed [15:0] ring_mem [SLOTS*SLOT_SZ];
  int unsigned        wr_pos, full_blocks, rd_slot, phase_acc;
  bit                 have_block, stream_ended, stream_done;
  logic signed [15:0] prev_frame [CH_MAX];

  function automatic int unsigned live_chans();
    if (chans_q == 0) return 1;
    if (chans_q > CH_MAX) return CH_MAX;
    return chans_q;
  endfunction

  function automatic logic signed [15:0] read_frame(int unsigned f, int unsigned c,
                                                    int unsigned n);
    if (f == 0) return prev_frame[c];
    return ring_mem[rd_slot*SLOT_SZ + (f-1)*n + c];
  endfunction

  function automatic void note_status(logic [1:0] st);
    frame_result_t r;
    r = '{status: st, chan: 3'd0, value: 16'd0, last: 1'b1};
    expected_q.push_back(r);
  endfunction

  function automatic void store_sample(logic [15:0] s);
    int unsigned n, slot, off;
    n = live_chans();
    if (stream_ended) return;
    if (full_blocks + (have_block ? 1 : 0) >= SLOTS) begin
      note_status(ST_DROPPED);
      return;
    end
    slot = wr_pos / SLOT_SZ;
    off = wr_pos % SLOT_SZ;
    ring_mem[slot*SLOT_SZ + off] = s;
    off++;
    if (off >= FRAMES*n) begin
      full_blocks++;
      slot = (slot + 1) % SLOTS;
      off = 0;
    end
    wr_pos = slot*SLOT_SZ + off;
  endfunction

  function automatic void interpolate_tick();
    int unsigned n, idx;
    longint alpha, diff, prod;
    logic signed [15:0] s0, s1;
    frame_result_t r;
    n = live_chans();
    if (stream_done) begin
      note_status(ST_FINISHED);
      return;
    end
    if (!have_block || phase_acc >= PHASE_END) begin
      if (full_blocks == 0) begin
        if (stream_ended) begin
          stream_done = 1;
          note_status(ST_FINISHED);
        end else begin
          note_status(ST_NOT_READY);
        end
        return;
      end
      if (have_block) begin
        for (int c = 0; c < n; c++) prev_frame[c] = read_frame(FRAMES, c, n);
        rd_slot = (rd_slot + 1) % SLOTS;
      end
      have_block = 1;
      full_blocks--;
      phase_acc = phase_acc % PHASE_END;
    end
    idx = phase_acc >> 16;
    alpha = phase_acc & 32'hFFFF;
    for (int c = 0; c < n; c++) begin
      s0 = read_frame(idx, c, n);
      s1 = read_frame(idx + 1, c, n);
      diff = longint'(s1) - longint'(s0);
      prod = (alpha * diff) >>> 16;   // floor division
      r.status = ST_SAMPLE;
      r.chan = c[2:0];
      r.value = 16'(longint'(s0) + prod);
      r.last = (c + 1 == n);
      expected_q.push_back(r);
    end
    phase_acc = phase_acc + rate_q;
  endfunction

  always @(posedge clk) begin
    frame_result_t got, want;
    if (!rst_n) begin
      rate_q = RATE_RESET;
      chans_q = CHANNELS_RESET;
      wr_pos = 0;
      full_blocks = 0;
      rd_slot = 0;
      phase_acc = 0;
      have_block = 0;
      stream_ended = 0;
      stream_done = 0;
      foreach (prev_frame[i]) prev_frame[i] = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RATE) rate_q = cfg_data;
        else chans_q = cfg_data[3:0];
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          REQ_PUSH: store_sample(in_tdata);
          REQ_TICK: interpolate_tick();
          REQ_END:  stream_ended = 1;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = '{status: out_tuser, chan: out_tdata[2:0], value: out_tdata[18:3],
                last: out_tlast};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d chan=%0d value=%0d last=%0d",
                   $time, got.status, got.chan, $signed(got.value), got.last);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status=%0d chan=%0d value=%0d last=%0d",
                     $time, want.status, want.chan, $signed(want.value), want.last);
            $display("%0t:          actual   status=%0d chan=%0d value=%0d last=%0d",
                     $time, got.status, got.chan, $signed(got.value), got.last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/stream_resampling_sample_reader_unit_tb.sv =====
// Testbench top for stream_resampling_sample_reader_unit: drives requests, register
// writes and output back-pressure; srsr_checker predicts and checks the results.
// Depends on srsr_pkg, srsr_checker and the block's RTL.
module stream_resampling_sample_reader_unit_tb import srsr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int FILL_COUNT  = RING_BLOCKS_DEF * BLOCK_FRAMES_DEF * MAX_CHANNELS_DEF;
  localparam logic [1:0] REQ_BAD = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = REQ_PUSH;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = REG_RATE;
  logic [23:0] cfg_data = '0;
  int          pending;
  int          fail_count;
  int          cycles = 0;
  bit          burst_mode = 0;

  always #5 clk = ~clk;

  stream_resampling_sample_reader_unit u_top (.*);

  srsr_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output back-pressure: random stall before each transfer, none in burst mode.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = burst_mode ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready = 0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Called just after a falling edge; returns just after a falling edge with valid held.
  task automatic send_request(logic [1:0] req, logic [15:0] smp);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = req;
    in_tdata = smp;
    in_tvalid = 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_items(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      burst_mode = ($urandom_range(0, 9) == 0);
      if (pick < 9) send_request(REQ_PUSH, rand_sample());
      else if (pick < 18) send_request(REQ_TICK, 16'($urandom()));
      else send_request(REQ_BAD, 16'($urandom()));
    end
    burst_mode = 0;
  endtask

  initial begin
    logic [23:0] rate_pick [6];
    logic [3:0]  chan_pick [6];
    rate_pick = '{24'h000000, 24'hFFFFFF, 24'h010000, 24'h00C000, 24'h000000, 24'h02A5F3};
    chan_pick = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd5};
    rate_pick[4] = 24'($urandom_range(1, 24'h03FFFF));
    repeat (2) @(negedge clk);
    rst_n = 1;

    // Nothing pushed yet: tick is not ready; unknown request is ignored.
    send_request(REQ_TICK, 16'h0000);
    send_request(REQ_BAD, 16'hFFFF);
    drain_results();

    // Fill every slot completely at eight channels so no later read hits unwritten memory.
    write_reg(REG_CHANNELS, 24'd8);
    write_reg(REG_RATE, 24'h010000);
    for (int i = 0; i < FILL_COUNT; i++) begin
      burst_mode = (i % 3000) < 500;
      send_request(REQ_PUSH, (i < 4) ? (i[1] ? (i[0] ? 16'hFFFF : 16'h0000)
                                              : (i[0] ? 16'h7FFF : 16'h8000))
                                     : rand_sample());
    end
    burst_mode = 0;
    send_request(REQ_PUSH, 16'h1234);   // ring full: dropped
    send_request(REQ_TICK, 16'h0000);
    send_request(REQ_TICK, 16'h0000);
    send_request(REQ_PUSH, 16'h5555);   // still full with one block current
    drain_results();

    // Phases across register settings, idle between each.
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CHANNELS, 24'(chan_pick[p]));
      write_reg(REG_RATE, rate_pick[p]);
      random_items(25);
      drain_results();
    end

    // Refill at one channel so blocks keep coming, then run with a fractional rate.
    write_reg(REG_CHANNELS, 24'd1);
    write_reg(REG_RATE, 24'h01B3A1);
    for (int i = 0; i < 2 * BLOCK_FRAMES_DEF; i++) send_request(REQ_PUSH, rand_sample());
    random_items(40);
    drain_results();

    // End of stream: push ignored, ticks run out the queued blocks, then finished.
    write_reg(REG_CHANNELS, 24'd2);
    write_reg(REG_RATE, 24'hFFFFFF);
    send_request(REQ_END, 16'h0000);
    send_request(REQ_PUSH, 16'h7FFF);
    for (int i = 0; i < RING_BLOCKS_DEF + 4; i++) send_request(REQ_TICK, 16'h0000);
    drain_results();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
